// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task switcher.
// ----------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SWITCH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_LISTED = 2'd1,
    STAT_REFUSED    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CR_TAIL,
    ST_RM_FETCH,
    ST_RM_CLR,
    ST_SW_SAVE,
    ST_SW_NEXT,
    ST_DONE
  } state_t;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [31:0] FRAME_BYTES   = 32'd64;
  localparam logic [31:0] SP_ALIGN_MASK = 32'hFFFF_FFF8;

endpackage

// ===== hdl/rrts_link_tbl.sv =====
// ----------------------------------------------------------------------------
// rrts_link_tbl
// Run-list link table: one synchronous RAM entry per slot (valid, next slot).
// Entries never written read back as null.
// ----------------------------------------------------------------------------
module rrts_link_tbl #(
  parameter int TASKS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(TASKS)-1:0] waddr,
  input  logic                     wvalid,
  input  logic [$clog2(TASKS)-1:0] wnext,
  input  logic                     re,
  input  logic [$clog2(TASKS)-1:0] raddr,
  output logic                     rvalid,
  output logic [$clog2(TASKS)-1:0] rnext
);

  localparam int SW = $clog2(TASKS);

  logic [SW:0]      mem [TASKS];
  logic [SW:0]      rdata_r;
  logic [TASKS-1:0] written_r;
  logic             rd_written_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvalid, wnext};
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (we) begin
        written_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_written_r <= written_r[raddr];
      end
    end
  end

  assign rvalid = rd_written_r & rdata_r[SW];
  assign rnext  = rd_written_r ? rdata_r[SW-1:0] : '0;

endmodule

// ===== hdl/rrts_sp_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_sp_ram
// Saved stack pointer store: one 32-bit synchronous RAM entry per slot.
// ----------------------------------------------------------------------------
module rrts_sp_ram #(
  parameter int TASKS = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(TASKS)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic                     re,
  input  logic [$clog2(TASKS)-1:0] raddr,
  output logic [31:0]              rdata
);

  logic [31:0] mem [TASKS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/round_robin_task_switcher.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_switcher
// Round-robin task scheduler over TASKS slots with a linked run list.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. A create or a remove walks the run
// list, bounded by the single read port of the link table (one hop per cycle);
// a switch, a refused create, an ignored remove or a no-op needs no walk. The
// result register lets the next transaction be accepted while a result waits.
// No clearing pass runs after reset.
module round_robin_task_switcher #(
  parameter int TASKS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] task_slot, [35:4] sp_value, [67:36] stack_base, [91:68] stack_length
  input  logic [rrts_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] op
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] resume_sp, [35:32] resume_slot
  output logic [rrts_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [1:0]                         out_tuser
);

  localparam int SW = $clog2(TASKS);
  localparam logic [8:0] TASKS_LIM = 9'(TASKS);

  rrts_pkg::state_t  state_r, state_nxt;
  rrts_pkg::op_t     op_r;
  rrts_pkg::status_t status_r, status_nxt;
  logic [SW-1:0]     slot_r;
  logic [31:0]       sp_r;
  logic [31:0]       init_sp_r;
  logic [SW-1:0]     ptr_r, ptr_nxt;
  logic [SW-1:0]     cur_r, cur_nxt;
  logic [TASKS-1:0]  listed_r, listed_nxt;

  logic              out_tvalid_r;
  logic [31:0]       out_sp_r;
  logic [3:0]        out_slot_r;
  logic [1:0]        out_status_r;
  logic              out_load;

  rrts_pkg::op_t     in_op;
  logic [3:0]        in_slot;
  logic [SW-1:0]     in_idx;
  logic              in_range;
  logic              in_listed;
  logic              create_bad;
  logic              remove_bad;
  logic              accept;

  logic              lk_we, lk_wvalid, lk_re, lk_rvalid;
  logic [SW-1:0]     lk_waddr, lk_wnext, lk_raddr, lk_rnext;
  logic              sp_we, sp_re;
  logic [SW-1:0]     sp_waddr, sp_raddr, sw_next;
  logic [31:0]       sp_wdata, sp_rdata;

  assign in_op      = rrts_pkg::op_t'(in_tuser);
  assign in_slot    = in_tdata[3:0];
  assign in_idx     = SW'(in_slot);
  assign in_range   = (9'(in_slot) < TASKS_LIM);
  assign in_listed  = in_range ? listed_r[in_idx] : 1'b0;
  assign create_bad = (in_slot == 4'd0) || !in_range || in_listed;
  assign remove_bad = (in_slot == 4'd0) || !in_range || !in_listed;
  assign in_tready  = (state_r == rrts_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign sw_next    = lk_rvalid ? lk_rnext : '0;

  rrts_link_tbl #(.TASKS(TASKS)) u_link (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (lk_we),
    .waddr  (lk_waddr),
    .wvalid (lk_wvalid),
    .wnext  (lk_wnext),
    .re     (lk_re),
    .raddr  (lk_raddr),
    .rvalid (lk_rvalid),
    .rnext  (lk_rnext)
  );

  rrts_sp_ram #(.TASKS(TASKS)) u_sp (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            rrts_pkg::OP_CREATE: state_nxt = create_bad ? rrts_pkg::ST_DONE : rrts_pkg::ST_WALK;
            rrts_pkg::OP_REMOVE: state_nxt = remove_bad ? rrts_pkg::ST_DONE : rrts_pkg::ST_WALK;
            rrts_pkg::OP_SWITCH: state_nxt = rrts_pkg::ST_SW_SAVE;
            rrts_pkg::OP_NOP:    state_nxt = rrts_pkg::ST_DONE;
            default:             state_nxt = rrts_pkg::ST_DONE;
          endcase
        end
      end
      rrts_pkg::ST_WALK: begin
        if (op_r == rrts_pkg::OP_CREATE) begin
          if (!lk_rvalid) state_nxt = rrts_pkg::ST_CR_TAIL;
        end else if (!lk_rvalid) begin
          state_nxt = rrts_pkg::ST_DONE;
        end else if (lk_rnext == slot_r) begin
          state_nxt = rrts_pkg::ST_RM_FETCH;
        end
      end
      rrts_pkg::ST_CR_TAIL:  state_nxt = rrts_pkg::ST_DONE;
      rrts_pkg::ST_RM_FETCH: state_nxt = rrts_pkg::ST_RM_CLR;
      rrts_pkg::ST_RM_CLR:   state_nxt = rrts_pkg::ST_DONE;
      rrts_pkg::ST_SW_SAVE:  state_nxt = rrts_pkg::ST_SW_NEXT;
      rrts_pkg::ST_SW_NEXT:  state_nxt = rrts_pkg::ST_DONE;
      rrts_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = rrts_pkg::ST_IDLE;
      end
      default: state_nxt = rrts_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    lk_we      = 1'b0;
    lk_waddr   = slot_r;
    lk_wvalid  = 1'b0;
    lk_wnext   = '0;
    lk_re      = 1'b0;
    lk_raddr   = ptr_r;
    sp_we      = 1'b0;
    sp_waddr   = cur_r;
    sp_wdata   = sp_r;
    sp_re      = 1'b0;
    sp_raddr   = sw_next;
    ptr_nxt    = ptr_r;
    cur_nxt    = cur_r;
    status_nxt = status_r;
    listed_nxt = listed_r;
    out_load   = 1'b0;
    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (accept) begin
          ptr_nxt    = '0;
          lk_raddr   = '0;
          status_nxt = rrts_pkg::STAT_OK;
          unique case (in_op) inside
            rrts_pkg::OP_CREATE: begin
              if (create_bad) status_nxt = rrts_pkg::STAT_REFUSED;
              else lk_re = 1'b1;
            end
            rrts_pkg::OP_REMOVE: begin
              if (remove_bad) status_nxt = rrts_pkg::STAT_NOT_LISTED;
              else lk_re = 1'b1;
            end
            rrts_pkg::OP_SWITCH, rrts_pkg::OP_NOP: begin
              status_nxt = rrts_pkg::STAT_OK;
            end
            default: status_nxt = rrts_pkg::STAT_OK;
          endcase
        end
      end
      rrts_pkg::ST_WALK: begin
        if (!lk_rvalid) begin
          if (op_r == rrts_pkg::OP_CREATE) begin
            lk_we     = 1'b1;
            lk_waddr  = ptr_r;
            lk_wvalid = 1'b1;
            lk_wnext  = slot_r;
          end else begin
            status_nxt = rrts_pkg::STAT_NOT_LISTED;
          end
        end else if (op_r == rrts_pkg::OP_REMOVE && lk_rnext == slot_r) begin
          lk_re    = 1'b1;
          lk_raddr = slot_r;
        end else begin
          lk_re    = 1'b1;
          lk_raddr = lk_rnext;
          ptr_nxt  = lk_rnext;
        end
      end
      rrts_pkg::ST_RM_FETCH: begin
        lk_we     = 1'b1;
        lk_waddr  = ptr_r;
        lk_wvalid = lk_rvalid;
        lk_wnext  = lk_rnext;
      end
      rrts_pkg::ST_RM_CLR: begin
        lk_we              = 1'b1;
        listed_nxt[slot_r] = 1'b0;
      end
      rrts_pkg::ST_CR_TAIL: begin
        lk_we              = 1'b1;
        sp_we              = 1'b1;
        sp_waddr           = slot_r;
        sp_wdata           = init_sp_r;
        listed_nxt[slot_r] = 1'b1;
      end
      rrts_pkg::ST_SW_SAVE: begin
        sp_we    = 1'b1;
        lk_re    = 1'b1;
        lk_raddr = cur_r;
      end
      rrts_pkg::ST_SW_NEXT: begin
        sp_re   = 1'b1;
        cur_nxt = sw_next;
      end
      rrts_pkg::ST_DONE: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rrts_pkg::ST_IDLE;
      status_r     <= rrts_pkg::STAT_OK;
      ptr_r        <= '0;
      cur_r        <= '0;
      listed_r     <= TASKS'(1);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      ptr_r    <= ptr_nxt;
      cur_r    <= cur_nxt;
      listed_r <= listed_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      slot_r    <= in_idx;
      sp_r      <= in_tdata[35:4];
      init_sp_r <= (in_tdata[67:36] + 32'(in_tdata[91:68]) - rrts_pkg::FRAME_BYTES)
                   & rrts_pkg::SP_ALIGN_MASK;
    end
    if (out_load) begin
      out_sp_r     <= (op_r == rrts_pkg::OP_SWITCH) ? sp_rdata : 32'd0;
      out_slot_r   <= 4'(cur_r);
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_slot_r, out_sp_r};
  assign out_tuser  = out_status_r;

  a_main_listed: assert property (@(posedge clk) disable iff (!rst_n)
    listed_r[0])
    else $error("main task slot dropped from the run list");

  a_listed_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rrts_pkg::ST_CR_TAIL && state_r != rrts_pkg::ST_RM_CLR)
    |=> $stable(listed_r))
    else $error("listed flags changed outside create/remove commit");

  a_no_link_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrts_pkg::ST_IDLE || state_r == rrts_pkg::ST_DONE) |-> !lk_we)
    else $error("link table written while no transaction in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == rrts_pkg::ST_DONE)
    else $error("result presented without a finished transaction");

endmodule
